FILE: rtl/core/palette_fade_engine_unit_macros.svh
// Assertion macros shared by the palette fade engine RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PALETTE_FADE_ENGINE_UNIT_MACROS_SVH
`define PALETTE_FADE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("palette fade engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("palette fade engine: next-cycle check failed");

`endif

FILE: rtl/core/pfe_pkg.sv
// Package of the palette fade engine: codes, microcode types and the entry step function.
// Depends on nothing; used by pfe_seq, pfe_datapath and the top module of the block.
`timescale 1ns / 1ps

package pfe_pkg;

    // Operation codes of an input word.
    localparam logic [2:0] OP_WR_CUR = 3'd0;
    localparam logic [2:0] OP_WR_TGT = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Fade modes.
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_FADE_IN   = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
    localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
    localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_FADE_MODE   = 2'd0;
    localparam logic [1:0] REG_FIRST_ENTRY = 2'd1;
    localparam logic [1:0] REG_LAST_OFFSET = 2'd2;

    // Component step and full-white level.
    localparam logic [7:0] STEP  = 8'd32;
    localparam logic [7:0] WHITE = 8'd224;

    // Microprogram addresses.
    typedef logic [3:0] upc_t;
    localparam upc_t U_FETCH = 4'd0;
    localparam upc_t U_WR    = 4'd1;
    localparam upc_t U_START = 4'd2;
    localparam upc_t U_FILL  = 4'd3;
    localparam upc_t U_EMIT  = 4'd4;
    localparam upc_t U_READ  = 4'd5;
    localparam upc_t U_TICK  = 4'd6;
    localparam upc_t U_WALK  = 4'd7;
    localparam upc_t U_LOOP  = 4'd8;
    localparam upc_t U_FRAME = 4'd9;

    typedef enum logic [1:0] {
        J_ALWAYS   = 2'd0,
        J_DISPATCH = 2'd1,
        J_IF       = 2'd2
    } jump_t;

    typedef enum logic [1:0] {
        FL_SKIP_FILL = 2'd0,
        FL_INACTIVE  = 2'd1,
        FL_SKIP_WALK = 2'd2,
        FL_MORE      = 2'd3
    } flag_sel_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic      accept;
        logic      wr_in;
        logic      ptr_load;
        logic      clr_frame;
        logic      tick_chk;
        logic      fill_wr;
        logic      rd_issue;
        logic      rd_next;
        logic      rd_item;
        logic      step_wr;
        logic      ptr_inc;
        logic      frame_upd;
        logic      emit;
        jump_t     jump;
        flag_sel_t flag_sel;
        upc_t      target;
    } ctrl_t;

    // Status flags the datapath hands back for conditional jumps.
    typedef struct packed {
        logic skip_fill;
        logic inactive;
        logic skip_walk;
        logic more;
    } flags_t;

    // One frame step of a single entry; colors are packed {red, green, blue}.
    function automatic logic [23:0] step_entry(logic [2:0] mode, logic [23:0] cur,
                                               logic [23:0] tgt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] tr;
        logic [7:0] tg;
        logic [7:0] tb;
        logic       same;
        {r, g, b}    = cur;
        {tr, tg, tb} = tgt;
        same         = (cur == tgt);
        unique case (mode)
            MODE_FADE_IN:
            begin
                if (!same)
                begin
                    if (tb > b)      b = b + STEP;
                    else if (tg > g) g = g + STEP;
                    else if (tr > r) r = r + STEP;
                end
            end
            MODE_FADE_OUT:
            begin
                if (r != 8'd0)      r = r - STEP;
                else if (g != 8'd0) g = g - STEP;
                else if (b != 8'd0) b = b - STEP;
            end
            MODE_FLASH_IN:
            begin
                if (!same)
                begin
                    if (tb < b)      b = b - STEP;
                    else if (tg < g) g = g - STEP;
                    else if (tr < r) r = r - STEP;
                end
            end
            MODE_FLASH_OUT:
            begin
                if (r != WHITE)      r = r + STEP;
                else if (g != WHITE) g = g + STEP;
                else if (b != WHITE) b = b + STEP;
            end
            default:
            begin
                r = r;
            end
        endcase
        return {r, g, b};
    endfunction

endpackage

FILE: rtl/core/pfe_in_if.sv
// Input channel of the palette fade engine: one command word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [5:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, operation, entry_index, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, operation, entry_index, red_in, green_in, blue_in,
                  output ready);
endinterface

FILE: rtl/core/pfe_out_if.sv
// Result channel of the palette fade engine: one result word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       fade_done;

    modport source (output valid, red_out, green_out, blue_out, fade_done, input ready);
    modport sink (input valid, red_out, green_out, blue_out, fade_done, output ready);
endinterface

FILE: rtl/core/pfe_cfg_if.sv
// Configuration write channel of the palette fade engine.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [5:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface

FILE: rtl/core/pfe_seq.sv
// Microcode sequencer of the palette fade engine: control store, step counter, jumps.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2:0]      in_op,
    input  logic            out_busy,
    input  logic            out_ready,
    input  pfe_pkg::flags_t flags,
    output pfe_pkg::ctrl_t  act,
    output logic            in_ready
);

    // Control store: one word per microprogram step.
    function automatic pfe_pkg::ctrl_t ucode(pfe_pkg::upc_t addr);
        pfe_pkg::ctrl_t uw;
        uw        = '0;
        uw.jump   = pfe_pkg::J_ALWAYS;
        uw.target = pfe_pkg::U_FETCH;
        unique case (addr)
            pfe_pkg::U_FETCH:
            begin
                uw.accept = 1'b1;
                uw.jump   = pfe_pkg::J_DISPATCH;
            end
            pfe_pkg::U_WR:
            begin
                uw.wr_in  = 1'b1;
                uw.target = pfe_pkg::U_EMIT;
            end
            pfe_pkg::U_START:
            begin
                uw.ptr_load  = 1'b1;
                uw.clr_frame = 1'b1;
                uw.jump      = pfe_pkg::J_IF;
                uw.flag_sel  = pfe_pkg::FL_SKIP_FILL;
                uw.target    = pfe_pkg::U_EMIT;
            end
            pfe_pkg::U_FILL:
            begin
                uw.fill_wr  = 1'b1;
                uw.ptr_inc  = 1'b1;
                uw.jump     = pfe_pkg::J_IF;
                uw.flag_sel = pfe_pkg::FL_MORE;
                uw.target   = pfe_pkg::U_FILL;
            end
            pfe_pkg::U_EMIT:
            begin
                uw.emit = 1'b1;
            end
            pfe_pkg::U_READ:
            begin
                uw.rd_item = 1'b1;
                uw.target  = pfe_pkg::U_EMIT;
            end
            pfe_pkg::U_TICK:
            begin
                uw.ptr_load = 1'b1;
                uw.tick_chk = 1'b1;
                uw.jump     = pfe_pkg::J_IF;
                uw.flag_sel = pfe_pkg::FL_INACTIVE;
                uw.target   = pfe_pkg::U_EMIT;
            end
            pfe_pkg::U_WALK:
            begin
                uw.rd_issue = 1'b1;
                uw.jump     = pfe_pkg::J_IF;
                uw.flag_sel = pfe_pkg::FL_SKIP_WALK;
                uw.target   = pfe_pkg::U_FRAME;
            end
            pfe_pkg::U_LOOP:
            begin
                uw.step_wr  = 1'b1;
                uw.rd_next  = 1'b1;
                uw.ptr_inc  = 1'b1;
                uw.jump     = pfe_pkg::J_IF;
                uw.flag_sel = pfe_pkg::FL_MORE;
                uw.target   = pfe_pkg::U_LOOP;
            end
            pfe_pkg::U_FRAME:
            begin
                uw.frame_upd = 1'b1;
                uw.target    = pfe_pkg::U_EMIT;
            end
            default:
            begin
                uw.target = pfe_pkg::U_FETCH;
            end
        endcase
        return uw;
    endfunction

    pfe_pkg::upc_t  upc_reg;
    pfe_pkg::upc_t  upc_next;
    pfe_pkg::upc_t  dispatch;
    pfe_pkg::ctrl_t uw;
    logic           stall;
    logic           flag;

    assign uw       = ucode(upc_reg);
    assign in_ready = uw.accept;

    // A step waits on its handshake; its actions fire only once it proceeds.
    assign stall = (uw.accept && !in_valid) || (uw.emit && out_busy && !out_ready);
    assign act   = stall ? '0 : uw;

    // Entry point of each operation's routine.
    always_comb
    begin
        unique case (in_op)
            pfe_pkg::OP_WR_CUR: dispatch = pfe_pkg::U_WR;
            pfe_pkg::OP_WR_TGT: dispatch = pfe_pkg::U_WR;
            pfe_pkg::OP_START:  dispatch = pfe_pkg::U_START;
            pfe_pkg::OP_TICK:   dispatch = pfe_pkg::U_TICK;
            pfe_pkg::OP_READ:   dispatch = pfe_pkg::U_READ;
            default:            dispatch = pfe_pkg::U_EMIT;
        endcase
    end

    // Condition selected by the control word.
    always_comb
    begin
        unique case (uw.flag_sel)
            pfe_pkg::FL_SKIP_FILL: flag = flags.skip_fill;
            pfe_pkg::FL_INACTIVE:  flag = flags.inactive;
            pfe_pkg::FL_SKIP_WALK: flag = flags.skip_walk;
            pfe_pkg::FL_MORE:      flag = flags.more;
        endcase
    end

    // Next step address.
    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            unique case (uw.jump)
                pfe_pkg::J_ALWAYS:   upc_next = uw.target;
                pfe_pkg::J_DISPATCH: upc_next = dispatch;
                pfe_pkg::J_IF:       upc_next = flag ? uw.target : upc_reg + 4'd1;
                default:             upc_next = pfe_pkg::U_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pfe_pkg::U_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: rtl/core/pfe_datapath.sv
// Datapath of the palette fade engine: palette memories, pointer, frame count, result register.
// Depends on pfe_pkg and palette_fade_engine_unit_macros.svh.
`timescale 1ns / 1ps
`include "palette_fade_engine_unit_macros.svh"

module pfe_datapath #(
    parameter int ENTRIES    = 64,
    parameter int LAST_FRAME = 21
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pfe_pkg::ctrl_t  act,
    output pfe_pkg::flags_t flags,
    input  logic [2:0]      operation,
    input  logic [5:0]      entry_index,
    input  logic [7:0]      red_in,
    input  logic [7:0]      green_in,
    input  logic [7:0]      blue_in,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_addr,
    input  logic [5:0]      cfg_wdata,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic            fade_done
);

    localparam int AW = $clog2(ENTRIES);
    localparam int PW = ($clog2(ENTRIES + 1) > 7) ? $clog2(ENTRIES + 1) : 7;

    logic [2:0]    fade_mode_reg;
    logic [5:0]    first_entry_reg;
    logic [5:0]    last_offset_reg;
    logic [2:0]    op_reg;
    logic [5:0]    idx_reg;
    logic [23:0]   color_reg;
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [PW-1:0] ptr_plus;
    logic [4:0]    frame_cnt_reg;
    logic          done_reg;
    logic          out_valid_reg;
    logic [23:0]   out_color_reg;
    logic          out_done_reg;
    logic [23:0]   cur_mem [ENTRIES];
    logic [23:0]   tgt_mem [ENTRIES];
    logic [23:0]   cur_rdata_reg;
    logic [23:0]   tgt_rdata_reg;
    logic [PW-1:0] lo_ext;
    logic [PW-1:0] hi_ext;
    logic          range_empty;
    logic          last_entry;
    logic          fill_mode;
    logic          active;
    logic          idx_ok;
    logic          cur_we;
    logic          tgt_we;
    logic [AW-1:0] cur_waddr;
    logic [23:0]   cur_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    fill_byte;
    logic          loop_wr;
    logic          emit_other;

    // Range decode and mode decode.
    assign lo_ext      = PW'(first_entry_reg);
    assign hi_ext      = lo_ext + PW'(last_offset_reg);
    assign range_empty = (lo_ext >= PW'(ENTRIES));
    assign last_entry  = (ptr_reg == hi_ext) || (ptr_reg == PW'(ENTRIES - 1));
    assign fill_mode   = (fade_mode_reg == pfe_pkg::MODE_FADE_IN) ||
                         (fade_mode_reg == pfe_pkg::MODE_FLASH_IN);
    assign active      = (fade_mode_reg == pfe_pkg::MODE_FADE_IN) ||
                         (fade_mode_reg == pfe_pkg::MODE_FADE_OUT) ||
                         (fade_mode_reg == pfe_pkg::MODE_FLASH_IN) ||
                         (fade_mode_reg == pfe_pkg::MODE_FLASH_OUT);
    assign idx_ok      = ({{(PW - 6){1'b0}}, idx_reg} < PW'(ENTRIES));
    assign ptr_plus    = ptr_reg + PW'(1);
    assign fill_byte   = (fade_mode_reg == pfe_pkg::MODE_FLASH_IN) ? pfe_pkg::WHITE : 8'd0;

    assign flags.skip_fill = !fill_mode || range_empty;
    assign flags.inactive  = !active;
    assign flags.skip_walk = range_empty;
    assign flags.more      = !last_entry;

    // Configuration registers; the channel never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_mode_reg   <= pfe_pkg::MODE_NONE;
            first_entry_reg <= 6'd0;
            last_offset_reg <= 6'd63;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                pfe_pkg::REG_FADE_MODE:   fade_mode_reg   <= cfg_wdata[2:0];
                pfe_pkg::REG_FIRST_ENTRY: first_entry_reg <= cfg_wdata;
                pfe_pkg::REG_LAST_OFFSET: last_offset_reg <= cfg_wdata;
                default:                  fade_mode_reg   <= fade_mode_reg;
            endcase
        end
    end

    // Accepted word.
    always_ff @(posedge clk)
    begin
        if (act.accept)
        begin
            op_reg    <= operation;
            idx_reg   <= entry_index;
            color_reg <= {red_in, green_in, blue_in};
        end
    end

    // Entry pointer of the fill and walk loops.
    always_comb
    begin
        priority if (act.ptr_load) ptr_next = lo_ext;
        else if (act.ptr_inc)      ptr_next = ptr_plus;
        else                       ptr_next = ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
    end

    // Frame counter and done flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= 5'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (act.accept)
            begin
                done_reg <= 1'b0;
            end
            if (act.tick_chk)
            begin
                done_reg <= !active;
            end
            if (act.clr_frame)
            begin
                frame_cnt_reg <= 5'd0;
            end
            if (act.frame_upd)
            begin
                if (frame_cnt_reg >= 5'(LAST_FRAME))
                begin
                    frame_cnt_reg <= 5'd0;
                    done_reg      <= 1'b1;
                end
                else
                begin
                    frame_cnt_reg <= frame_cnt_reg + 5'd1;
                end
            end
        end
    end

    // Current palette write port: host write, range fill or stepped entry.
    assign cur_we    = (act.wr_in && (op_reg == pfe_pkg::OP_WR_CUR) && idx_ok) ||
                       act.fill_wr || act.step_wr;
    assign cur_waddr = act.wr_in ? AW'(idx_reg) : ptr_reg[AW-1:0];
    always_comb
    begin
        priority if (act.wr_in) cur_wdata = color_reg;
        else if (act.fill_wr)   cur_wdata = {3{fill_byte}};
        else                    cur_wdata = pfe_pkg::step_entry(fade_mode_reg, cur_rdata_reg,
                                                                tgt_rdata_reg);
    end
    assign tgt_we = act.wr_in && (op_reg == pfe_pkg::OP_WR_TGT) && idx_ok;

    // Shared read address: host read, first walk entry, or the one after the written entry.
    assign rd_en = act.rd_item || act.rd_issue || act.rd_next;
    always_comb
    begin
        priority if (act.rd_item) rd_addr = AW'(idx_reg);
        else if (act.rd_next)     rd_addr = ptr_plus[AW-1:0];
        else                      rd_addr = ptr_reg[AW-1:0];
    end

    // Palette memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (rd_en)
        begin
            cur_rdata_reg <= cur_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[AW'(idx_reg)] <= color_reg;
        end
        if (rd_en)
        begin
            tgt_rdata_reg <= tgt_mem[rd_addr];
        end
    end

    // Result register, decoupled from the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act.emit)
        begin
            out_color_reg <= ((op_reg == pfe_pkg::OP_READ) && idx_ok) ? cur_rdata_reg : 24'd0;
            out_done_reg  <= done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_color_reg[23:16];
    assign green_out = out_color_reg[15:8];
    assign blue_out  = out_color_reg[7:0];
    assign fade_done = out_done_reg;

    // Terms of the checks below.
    assign loop_wr    = act.fill_wr || act.step_wr;
    assign emit_other = act.emit && (op_reg != pfe_pkg::OP_READ);

    // Checks on the walk, the frame counter and the result register.
    `PFE_ASSERT_IMPL(a_walk_in_memory, clk, rst_n, loop_wr, ptr_reg < PW'(ENTRIES))
    `PFE_ASSERT_IMPL(a_frame_bound, clk, rst_n, 1'b1, frame_cnt_reg <= 5'(LAST_FRAME))
    `PFE_ASSERT_NEXT(a_emit_loads, clk, rst_n, act.emit, out_valid_reg)
    `PFE_ASSERT_NEXT(a_color_only_on_read, clk, rst_n, emit_other, out_color_reg == 24'd0)

endmodule

FILE: rtl/core/palette_fade_engine_unit.sv
// Palette fade engine, a sequenced read-modify-write engine over two palette memories.
// A start fade fills the range in fade-in and flash-in modes; a frame tick walks the N
// entries in range, N up to 64, unless no fade mode is active: the current palette memory
// has one write port, so the fill and walk loops handle one entry per cycle, reading the
// next entry while the stepped one is written back. A new word is taken while the previous
// result still waits on the result channel. Depends on pfe_pkg, the channel interfaces,
// pfe_seq and pfe_datapath.
`timescale 1ns / 1ps

module palette_fade_engine_unit #(
    parameter int ENTRIES    = 64,
    parameter int LAST_FRAME = 21
) (
    input logic        clk,
    input logic        rst_n,
    pfe_in_if.sink     item,
    pfe_out_if.source  result,
    pfe_cfg_if.sink    cfg
);

    pfe_pkg::ctrl_t  act;
    pfe_pkg::flags_t flags;
    logic            out_valid;

    // Configuration writes are taken in any cycle.
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid;

    pfe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_op     (item.operation),
        .out_busy  (out_valid),
        .out_ready (result.ready),
        .flags     (flags),
        .act       (act),
        .in_ready  (item.ready)
    );

    pfe_datapath #(
        .ENTRIES    (ENTRIES),
        .LAST_FRAME (LAST_FRAME)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .act         (act),
        .flags       (flags),
        .operation   (item.operation),
        .entry_index (item.entry_index),
        .red_in      (item.red_in),
        .green_in    (item.green_in),
        .blue_in     (item.blue_in),
        .cfg_valid   (cfg.valid),
        .cfg_addr    (cfg.addr),
        .cfg_wdata   (cfg.wdata),
        .out_valid   (out_valid),
        .out_ready   (result.ready),
        .red_out     (result.red_out),
        .green_out   (result.green_out),
        .blue_out    (result.blue_out),
        .fade_done   (result.fade_done)
    );

endmodule
